// ===== rtl/core/msa_pkg.sv =====
package msa_pkg;

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_TOP     = 3'd1,
    OP_POP     = 3'd2,
    OP_FIND    = 3'd3,
    OP_SET_TOP = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    CFG_HEAP_END  = 2'd0,
    CFG_MAX_REQ   = 2'd1,
    CFG_ROUND_POS = 2'd2,
    CFG_ROUND_NEG = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROUND,
    ST_LIMIT,
    ST_ADD,
    ST_CMP,
    ST_CHK,
    ST_LOW,
    ST_POP_RD,
    ST_POP,
    ST_FIND_RD,
    ST_FIND,
    ST_RESP
  } state_e;

  localparam logic [31:0] HEAP_BASE      = 32'h8009_65B0;
  localparam logic [31:0] HEAP_END_RST   = 32'h801C_35B0;
  localparam logic [30:0] MAX_REQ_RST    = 31'h7FFF_FFFF;
  localparam logic [3:0]  ROUND_POS_RST  = 4'd7;
  localparam logic [3:0]  ROUND_NEG_RST  = 4'd14;
  // 8-byte granule: floor rounding of a two's complement sum is a mask
  localparam logic [31:0] ALIGN_MASK     = 32'hFFFF_FFF8;

endpackage

// ===== rtl/core/msa_ram.sv =====
module msa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/mark_release_stack_allocator_top.sv =====
// Channel   Handshake                  Payload
// in        in_valid_i / in_stall_o    operation_i, size_i, address_i, stack_index_i
// out       out_valid_o / out_stall_i  success_o, block_address_o, index_out_o,
//                                      aligned_bytes_o, previous_cursor_o, next_cursor_o
// cfg       cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// One transaction at a time through a single 33-bit add/subtract unit under a sequencer.
// Each operation runs through its own states; set top with size < 0 and an unknown code
// go straight to the response; find compares one mark per RAM read, up to depth.
// Reset clears marks at once through per-entry valid bits; no sweep is needed.
// A finished result waits in the output register while the next transaction is taken;
// the sequencer holds in its response step only if that register is still full.
module mark_release_stack_allocator_top
  import msa_pkg::*;
#(
  parameter int unsigned STACK_ENTRIES = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         operation_i,
  input  logic signed [31:0] size_i,
  input  logic [31:0]        address_i,
  input  logic [7:0]         stack_index_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               success_o,
  output logic [31:0]        block_address_o,
  output logic [7:0]         index_out_o,
  output logic [31:0]        aligned_bytes_o,
  output logic [31:0]        previous_cursor_o,
  output logic [31:0]        next_cursor_o
);

  localparam int unsigned IW = $clog2(STACK_ENTRIES);
  localparam logic [IW:0] ENTRIES_W = (IW+1)'(STACK_ENTRIES);
  localparam logic [8:0]  ENTRIES_9 = 9'(STACK_ENTRIES);

  // configuration
  logic [31:0] heap_end_q;
  logic [30:0] max_req_q;
  logic [3:0]  round_pos_q, round_neg_q;

  // allocator state
  logic [31:0]              cursor_q, cursor_d;
  logic [IW-1:0]            depth_q, depth_d;
  logic [31:0]              low_water_q, low_water_d;
  logic [STACK_ENTRIES-1:0] valid_q, valid_d;

  // sequencer
  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic [31:0]   sz_q, sz_d, addr_q, addr_d;
  logic [7:0]    sidx_q, sidx_d;
  logic [31:0]   alb_q, alb_d, nc_q, nc_d, blk_q, blk_d;
  logic          ok_q, ok_d, lw_upd_q, lw_upd_d;
  logic [7:0]    idx_q, idx_d;
  logic [IW-1:0] scan_q, scan_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic        succ_q, succ_d;
  logic [31:0] oblk_q, oblk_d, oalb_q, oalb_d, oprev_q, oprev_d, onext_q, onext_d;
  logic [7:0]  oidx_q, oidx_d;

  // mark RAM
  logic          ram_we;
  logic [IW-1:0] ram_waddr, rd_addr;
  logic [31:0]   ram_wdata, ram_rdata, mark_rd;
  logic          rd_valid_q;

  // shared arithmetic unit
  logic [31:0] unit_a, unit_b;
  logic        unit_sub;
  logic [32:0] unit_sum;
  logic        unit_carry;

  logic [IW:0] ni;
  logic        push_ok;

  assign mark_rd = rd_valid_q ? ram_rdata : '0;
  assign ni      = {1'b0, depth_q} + (IW+1)'(1);
  assign push_ok = ok_q && (ni < ENTRIES_W);

  always_comb begin
    unit_a   = '0;
    unit_b   = '0;
    unit_sub = 1'b0;
    unique case (state_q)
      ST_ROUND: begin
        unit_a = sz_q;
        unit_b = {28'd0, sz_q[31] ? round_neg_q : round_pos_q};
      end
      ST_LIMIT: begin
        unit_a   = {1'b0, max_req_q};
        unit_b   = sz_q;
        unit_sub = 1'b1;
      end
      ST_ADD: begin
        unit_a = (op_q == OP_SET_TOP) ? addr_q : cursor_q;
        unit_b = (op_q == OP_SET_TOP) ? sz_q : alb_q;
      end
      ST_CMP: begin
        unit_a   = nc_q;
        unit_b   = heap_end_q;
        unit_sub = 1'b1;
      end
      ST_CHK: begin
        unit_a   = heap_end_q;
        unit_b   = alb_q;
        unit_sub = 1'b1;
      end
      ST_LOW: begin
        unit_a   = low_water_q;
        unit_b   = blk_q;
        unit_sub = 1'b1;
      end
      ST_FIND: begin
        unit_a   = mark_rd;
        unit_b   = addr_q;
        unit_sub = 1'b1;
      end
      default: ;
    endcase
    // carry out of a subtract means a >= b
    unit_sum   = {1'b0, unit_a} + {1'b0, unit_b ^ {32{unit_sub}}} + 33'(unit_sub);
    unit_carry = unit_sum[32];
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    sz_d        = sz_q;
    addr_d      = addr_q;
    sidx_d      = sidx_q;
    alb_d       = alb_q;
    nc_d        = nc_q;
    blk_d       = blk_q;
    ok_d        = ok_q;
    lw_upd_d    = lw_upd_q;
    idx_d       = idx_q;
    scan_d      = scan_q;
    cursor_d    = cursor_q;
    depth_d     = depth_q;
    low_water_d = low_water_q;
    valid_d     = valid_q;
    out_valid_d = out_valid_q && out_stall_i;
    succ_d      = succ_q;
    oblk_d      = oblk_q;
    oidx_d      = oidx_q;
    oalb_d      = oalb_q;
    oprev_d     = oprev_q;
    onext_d     = onext_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    rd_addr     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d     = op_e'(operation_i);
          sz_d     = size_i;
          addr_d   = address_i;
          sidx_d   = stack_index_i;
          alb_d    = '0;
          ok_d     = 1'b0;
          idx_d    = '0;
          lw_upd_d = 1'b0;
          case (op_e'(operation_i))
            OP_PUSH, OP_TOP: begin
              ok_d    = 1'b1;
              state_d = ST_ROUND;
            end
            OP_POP:  state_d = ST_POP_RD;
            OP_FIND: state_d = ST_FIND_RD;
            OP_SET_TOP: begin
              if (size_i[31]) begin
                state_d = ST_RESP;
              end else begin
                idx_d   = stack_index_i;
                ok_d    = {1'b0, stack_index_i} < ENTRIES_9;
                state_d = ST_ADD;
              end
            end
            default: state_d = ST_RESP;
          endcase
        end
      end
      ST_ROUND: begin
        alb_d   = unit_sum[31:0] & ALIGN_MASK;
        state_d = (op_q == OP_PUSH) ? ST_LIMIT : ST_ADD;
      end
      ST_LIMIT: begin
        ok_d    = ok_q && (sz_q[31] || unit_carry);
        state_d = ST_ADD;
      end
      ST_ADD: begin
        nc_d    = unit_sum[31:0];
        ok_d    = ok_q && !unit_carry;
        state_d = ST_CMP;
      end
      ST_CMP: begin
        ok_d    = ok_q && !unit_carry;
        state_d = (op_q == OP_TOP) ? ST_CHK : ST_RESP;
      end
      ST_CHK: begin
        ok_d    = ok_q && unit_carry;
        blk_d   = unit_sum[31:0];
        state_d = ST_LOW;
      end
      ST_LOW: begin
        lw_upd_d = !unit_carry;
        state_d  = ST_RESP;
      end
      ST_POP_RD: begin
        rd_addr = depth_q;
        state_d = ST_POP;
      end
      ST_POP: begin
        ok_d    = depth_q != '0;
        idx_d   = 8'(depth_q);
        nc_d    = mark_rd;
        state_d = ST_RESP;
      end
      ST_FIND_RD: begin
        if (depth_q == '0) begin
          state_d = ST_RESP;
        end else begin
          rd_addr = IW'(1);
          scan_d  = IW'(1);
          state_d = ST_FIND;
        end
      end
      ST_FIND: begin
        if (unit_sum[31:0] == '0) begin
          ok_d    = 1'b1;
          idx_d   = 8'(scan_q);
          state_d = ST_RESP;
        end else if (scan_q == depth_q) begin
          state_d = ST_RESP;
        end else begin
          scan_d  = scan_q + IW'(1);
          rd_addr = scan_q + IW'(1);
        end
      end
      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          succ_d      = 1'b0;
          oblk_d      = '0;
          oidx_d      = '0;
          oalb_d      = '0;
          oprev_d     = '0;
          onext_d     = '0;
          case (op_q)
            OP_PUSH: begin
              succ_d  = push_ok;
              oalb_d  = alb_q;
              oprev_d = cursor_q;
              onext_d = push_ok ? nc_q : cursor_q;
              if (push_ok) begin
                oblk_d                  = cursor_q;
                oidx_d                  = 8'(ni);
                ram_we                  = 1'b1;
                ram_waddr               = ni[IW-1:0];
                ram_wdata               = cursor_q;
                valid_d[ni[IW-1:0]]     = 1'b1;
                depth_d                 = ni[IW-1:0];
                cursor_d                = nc_q;
              end
            end
            OP_TOP: begin
              succ_d  = ok_q;
              oalb_d  = alb_q;
              oprev_d = cursor_q;
              onext_d = cursor_q;
              if (ok_q) begin
                oblk_d = blk_q;
                if (lw_upd_q) begin
                  low_water_d = blk_q;
                end
              end
            end
            OP_POP: begin
              succ_d = ok_q;
              if (ok_q) begin
                oidx_d           = idx_q;
                onext_d          = nc_q;
                valid_d[depth_q] = 1'b0;
                cursor_d         = nc_q;
                depth_d          = depth_q - IW'(1);
              end
            end
            OP_FIND: begin
              succ_d = ok_q;
              oidx_d = idx_q;
            end
            OP_SET_TOP: begin
              succ_d = ok_q;
              oidx_d = idx_q;
              if (ok_q) begin
                onext_d                 = nc_q;
                ram_we                  = 1'b1;
                ram_waddr               = sidx_q[IW-1:0];
                ram_wdata               = addr_q;
                valid_d[sidx_q[IW-1:0]] = 1'b1;
                depth_d                 = sidx_q[IW-1:0];
                cursor_d                = nc_q;
              end
            end
            default: ;
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_end_q  <= HEAP_END_RST;
      max_req_q   <= MAX_REQ_RST;
      round_pos_q <= ROUND_POS_RST;
      round_neg_q <= ROUND_NEG_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_HEAP_END:  heap_end_q  <= cfg_wdata_i;
        CFG_MAX_REQ:   max_req_q   <= cfg_wdata_i[30:0];
        CFG_ROUND_POS: round_pos_q <= cfg_wdata_i[3:0];
        CFG_ROUND_NEG: round_neg_q <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cursor_q    <= HEAP_BASE;
      depth_q     <= '0;
      low_water_q <= '0;
      valid_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cursor_q    <= cursor_d;
      depth_q     <= depth_d;
      low_water_q <= low_water_d;
      valid_q     <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    sz_q       <= sz_d;
    addr_q     <= addr_d;
    sidx_q     <= sidx_d;
    alb_q      <= alb_d;
    nc_q       <= nc_d;
    blk_q      <= blk_d;
    ok_q       <= ok_d;
    lw_upd_q   <= lw_upd_d;
    idx_q      <= idx_d;
    scan_q     <= scan_d;
    succ_q     <= succ_d;
    oblk_q     <= oblk_d;
    oidx_q     <= oidx_d;
    oalb_q     <= oalb_d;
    oprev_q    <= oprev_d;
    onext_q    <= onext_d;
    rd_valid_q <= valid_q[rd_addr];
  end

  msa_ram #(
    .WIDTH(32),
    .DEPTH(STACK_ENTRIES)
  ) u_mark_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign success_o         = succ_q;
  assign block_address_o   = oblk_q;
  assign index_out_o       = oidx_q;
  assign aligned_bytes_o   = oalb_q;
  assign previous_cursor_o = oprev_q;
  assign next_cursor_o     = onext_q;

endmodule

// ===== sim/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import msa_pkg::*;

  localparam int MARKS = 32;
  localparam int GRANULE = 8;
  localparam logic [31:0] CURSOR_AT_RESET = 32'h8009_65B0;
  localparam logic [31:0] HEAP_END_AT_RESET = 32'h801C_35B0;
  localparam logic [2:0] OP_CODE_MAX = 3'd7;
  localparam int DRAIN_CYCLES = 40;
  localparam int QUIET_LIMIT = 3000;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] size;
    logic [31:0] addr;
    logic [7:0]  sidx;
  } alloc_req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] blk;
    logic [7:0]  idx;
    logic [31:0] alb;
    logic [31:0] prev;
    logic [31:0] next;
  } alloc_rsp_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = '0;
  logic [31:0]        cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         operation_i = '0;
  logic signed [31:0] size_i = '0;
  logic [31:0]        address_i = '0;
  logic [7:0]         stack_index_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               success_o;
  logic [31:0]        block_address_o;
  logic [7:0]         index_out_o;
  logic [31:0]        aligned_bytes_o;
  logic [31:0]        previous_cursor_o;
  logic [31:0]        next_cursor_o;

  mark_release_stack_allocator_top #(
    .STACK_ENTRIES(MARKS)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .size_i           (size_i),
    .address_i        (address_i),
    .stack_index_i    (stack_index_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .success_o        (success_o),
    .block_address_o  (block_address_o),
    .index_out_o      (index_out_o),
    .aligned_bytes_o  (aligned_bytes_o),
    .previous_cursor_o(previous_cursor_o),
    .next_cursor_o    (next_cursor_o)
  );

  // allocator shadow: configuration and state
  logic [31:0] heap_end = HEAP_END_AT_RESET;
  logic [30:0] max_request = 31'h7FFF_FFFF;
  logic [3:0]  round_pos = 4'd7;
  logic [3:0]  round_neg = 4'd14;
  logic [31:0] heap_cursor = CURSOR_AT_RESET;
  logic [7:0]  mark_depth = '0;
  logic [31:0] mark_tbl [MARKS];
  logic [31:0] low_water = '0;

  alloc_req_t request_q[$];
  alloc_rsp_t outcome_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // floor rounding of a two's complement sum just clears the low bits
  function automatic logic [31:0] rounded_bytes(logic [31:0] sz);
    logic [32:0] adj;
    adj = {sz[31], sz} + {29'd0, sz[31] ? round_neg : round_pos};
    return adj[31:0] & ~32'(GRANULE - 1);
  endfunction

  function automatic alloc_rsp_t alloc_outcome(alloc_req_t r);
    alloc_rsp_t o;
    logic [32:0] sum;
    logic        fits;
    logic [7:0]  d;
    int          lim;
    int          i;
    o = '0;
    case (r.op)
      OP_PUSH, OP_TOP: begin
        o.alb = rounded_bytes(r.size);
        o.prev = heap_cursor;
        o.next = heap_cursor;
        sum = {1'b0, heap_cursor} + {1'b0, o.alb};
        fits = !sum[32] && sum[31:0] < heap_end;
        if (r.op == OP_TOP) begin
          if (fits && o.alb <= heap_end) begin
            o.ok = 1'b1;
            o.blk = heap_end - o.alb;
            if (o.blk > low_water) low_water = o.blk;
          end
        end else begin
          d = mark_depth + 8'd1;
          if (fits && $signed(r.size) <= $signed({1'b0, max_request}) && d < MARKS) begin
            o.ok = 1'b1;
            o.blk = heap_cursor;
            o.idx = d;
            o.next = sum[31:0];
            mark_tbl[d] = heap_cursor;
            mark_depth = d;
            heap_cursor = sum[31:0];
          end
        end
      end
      OP_POP: begin
        d = mark_depth;
        if (d != 0 && d < MARKS) begin
          o.ok = 1'b1;
          o.idx = d;
          o.next = mark_tbl[d];
          mark_tbl[d] = '0;
          heap_cursor = o.next;
          mark_depth = d - 8'd1;
        end
      end
      OP_FIND: begin
        lim = (mark_depth > MARKS - 1) ? MARKS - 1 : int'(mark_depth);
        for (i = 1; i <= lim && !o.ok; i++) begin
          if (mark_tbl[i] == r.addr) begin
            o.ok = 1'b1;
            o.idx = 8'(i);
          end
        end
      end
      OP_SET_TOP: begin
        if (!r.size[31]) begin
          o.idx = r.sidx;
          sum = {1'b0, r.addr} + {1'b0, r.size};
          if (r.sidx < MARKS && !sum[32] && sum[31:0] < heap_end) begin
            mark_tbl[r.sidx] = r.addr;
            mark_depth = r.sidx;
            heap_cursor = sum[31:0];
            o.ok = 1'b1;
            o.next = sum[31:0];
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] actual);
    if (want !== actual) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, actual);
      errors++;
    end
  endfunction

  function automatic alloc_req_t req_of(logic [2:0] op, logic [31:0] size, logic [31:0] addr,
                                        logic [7:0] sidx);
    alloc_req_t r;
    r.op = op;
    r.size = size;
    r.addr = addr;
    r.sidx = sidx;
    return r;
  endfunction

  function automatic logic [31:0] pick_size();
    int k;
    k = $urandom_range(99);
    if (k < 60) return 32'($urandom_range(0, 512));
    if (k < 75) return -32'($urandom_range(1, 64));
    if (k < 85) return {1'b0, max_request} + 32'($urandom_range(0, 1));
    return $urandom;
  endfunction

  // mostly well-formed traffic built around the current shadow state
  function automatic alloc_req_t random_req();
    alloc_req_t r;
    int k;
    int j;
    r = req_of(OP_POP, $urandom, $urandom, 8'($urandom));
    k = $urandom_range(99);
    j = $urandom_range(9);
    if (k < 34) begin
      r.op = OP_PUSH;
      r.size = pick_size();
    end else if (k < 44) begin
      r.op = OP_TOP;
      r.size = pick_size();
    end else if (k < 68) begin
      r.op = OP_POP;
    end else if (k < 84) begin
      r.op = OP_FIND;
      if (j < 6 && mark_depth != 0) r.addr = mark_tbl[$urandom_range(1, mark_depth)];
      else if (j < 7) r.addr = '0;
      else if (j < 8) r.addr = heap_cursor;
    end else if (k < 95) begin
      r.op = OP_SET_TOP;
      if (j < 8) r.sidx = 8'($urandom_range(0, MARKS - 1));
      if ($urandom_range(9) < 8) r.size = 32'($urandom_range(0, 256));
      if ($urandom_range(9) < 8) r.addr = heap_end - 32'($urandom_range(32'h200, 32'h8000));
    end else begin
      r.op = 3'($urandom_range(int'(OP_SET_TOP) + 1, int'(OP_CODE_MAX)));
    end
    return r;
  endfunction

  task automatic issue(alloc_req_t r);
    while (request_q.size() != 0) @(negedge clk_i);
    request_q.push_back(r);
  endtask

  task automatic wait_idle();
    while (request_q.size() != 0 || in_valid_i || outcome_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    case (idx)
      CFG_HEAP_END:  heap_end = v;
      CFG_MAX_REQ:   max_request = v[30:0];
      CFG_ROUND_POS: round_pos = v[3:0];
      CFG_ROUND_NEG: round_neg = v[3:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic run_chunk(int idle_in, int stall_out, logic [31:0] he, logic [30:0] mr,
                           logic [3:0] pos, logic [3:0] neg, int n);
    int i;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    // unused upper bits of the narrow registers carry noise
    write_reg(CFG_HEAP_END, he);
    write_reg(CFG_MAX_REQ, {1'($urandom), mr});
    write_reg(CFG_ROUND_POS, {28'($urandom), pos});
    write_reg(CFG_ROUND_NEG, {28'($urandom), neg});
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    send_idle_pct = idle_in;
    recv_stall_pct = stall_out;
    for (i = 0; i < n; i++) begin
      if (i % 64 == 63) wait_idle();
      issue(random_req());
    end
  endtask

  always @(posedge clk_i) begin : drive
    alloc_req_t seen;
    alloc_req_t nxt;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        seen = req_of(operation_i, size_i, address_i, stack_index_i);
        outcome_q.push_back(alloc_outcome(seen));
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = request_q.pop_front();
          in_valid_i <= 1'b1;
          operation_i <= nxt.op;
          size_i <= nxt.size;
          address_i <= nxt.addr;
          stack_index_i <= nxt.sidx;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : observe
    alloc_rsp_t w;
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      if (out_valid_o && !out_stall_i) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual ok=%b blk=%h idx=%0d",
                   $time, success_o, block_address_o, index_out_o);
          errors++;
        end else begin
          w = outcome_q.pop_front();
          check_field("success", 32'(w.ok), 32'(success_o));
          check_field("block_address", w.blk, block_address_o);
          check_field("index_out", 32'(w.idx), 32'(index_out_o));
          check_field("aligned_bytes", w.alb, aligned_bytes_o);
          check_field("previous_cursor", w.prev, previous_cursor_o);
          check_field("next_cursor", w.next, next_cursor_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    foreach (mark_tbl[i]) mark_tbl[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_idle_pct = 36;
    recv_stall_pct = 77;

    // directed pass on reset configuration
    issue(req_of(OP_POP, 32'd0, 32'd0, 8'd0));                 // pop on empty stack
    issue(req_of(OP_FIND, 32'd0, 32'd0, 8'd0));                // find with no marks
    issue(req_of(OP_PUSH, 32'd0, 32'd0, 8'd0));
    issue(req_of(OP_PUSH, 32'hFFFF_FFFF, 32'd0, 8'd0));        // negative rounds up to 8
    issue(req_of(OP_PUSH, 32'h8000_0000, 32'd0, 8'd0));
    issue(req_of(OP_PUSH, 32'h7FFF_FFFF, 32'd0, 8'd0));
    issue(req_of(OP_PUSH, 32'd1, 32'd0, 8'd0));
    issue(req_of(OP_TOP, 32'd100, 32'd0, 8'd0));
    issue(req_of(OP_TOP, 32'h7FFF_FFFF, 32'd0, 8'd0));
    issue(req_of(OP_TOP, 32'h8000_0000, 32'd0, 8'd0));
    issue(req_of(OP_FIND, 32'd0, CURSOR_AT_RESET, 8'd0));      // first of two equal marks
    issue(req_of(OP_FIND, 32'd0, CURSOR_AT_RESET + 32'd8, 8'd0));
    issue(req_of(OP_FIND, 32'd0, 32'h1234_5678, 8'd0));
    issue(req_of(OP_POP, 32'd0, 32'd0, 8'd0));
    issue(req_of(OP_SET_TOP, 32'hFFFF_FFFF, CURSOR_AT_RESET, 8'd1));
    issue(req_of(OP_SET_TOP, 32'd0, CURSOR_AT_RESET, 8'hFF));
    issue(req_of(OP_SET_TOP, 32'd0, CURSOR_AT_RESET, 8'(MARKS)));
    issue(req_of(OP_SET_TOP, 32'h100, 32'hFFFF_FFF0, 8'd5));    // address wraps
    issue(req_of(OP_SET_TOP, 32'd8, HEAP_END_AT_RESET - 32'd8, 8'd5));
    issue(req_of(OP_SET_TOP, 32'h10, CURSOR_AT_RESET + 32'h1000, 8'(MARKS - 1)));
    issue(req_of(OP_PUSH, 32'd8, 32'd0, 8'd0));                // stack full
    issue(req_of(OP_FIND, 32'd0, CURSOR_AT_RESET + 32'h1000, 8'd0));
    issue(req_of(OP_FIND, 32'd0, 32'd0, 8'd0));                // hits a cleared mark
    issue(req_of(OP_POP, 32'd0, 32'd0, 8'd0));
    issue(req_of(OP_SET_TOP, 32'd0, CURSOR_AT_RESET, 8'd0));
    issue(req_of(OP_POP, 32'd0, 32'd0, 8'd0));
    issue(req_of(OP_SET_TOP + 3'd1, $urandom, $urandom, 8'($urandom)));
    issue(req_of(OP_CODE_MAX, $urandom, $urandom, 8'($urandom)));

    run_chunk(36, 77, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 4'd15, 4'd0, 100);
    run_chunk(36, 77, HEAP_END_AT_RESET, 31'd0, 4'd0, 4'd15, 100);
    run_chunk(77, 36, CURSOR_AT_RESET + 32'($urandom_range(32'h400, 32'h4_0000)),
              31'($urandom_range(0, 4096)), 4'($urandom), 4'($urandom), 100);
    run_chunk(77, 36, 32'd0, 31'h7FFF_FFFF, 4'd7, 4'd14, 30);
    run_chunk(0, 0, 32'h8010_0000, 31'd4096, 4'd7, 4'd14, 110);
    run_chunk(0, 0, $urandom, 31'($urandom), 4'($urandom), 4'($urandom), 110);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/msa_pkg.sv
rtl/core/msa_ram.sv
rtl/core/mark_release_stack_allocator_top.sv
sim/tb.sv
